// File: design/rleu_pkg.sv
// Shared types and codes for the run-length unit decompressor.
// No dependencies; imported by every module of the block.
`default_nettype none

package rleu_pkg;

    // Decoder phase
    typedef enum logic [1:0] {
        PH_DONE    = 2'd0,
        PH_COUNT   = 2'd1,
        PH_PATTERN = 2'd2,
        PH_REPEAT  = 2'd3
    } phase_t;

    // Request kind, as carried on s_tuser
    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_PULL  = 2'd1,
        OP_START = 2'd2,
        OP_BAD   = 2'd3
    } op_t;

    // Result status, as carried on m_tuser
    localparam logic [1:0] ST_BYTE    = 2'd0;
    localparam logic [1:0] ST_TAKEN   = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    // Configuration register indexes
    localparam logic CFG_UNIT_MODE = 1'b0;
    localparam logic CFG_OUT_SIZE  = 1'b1;

    // Unit mode codes
    localparam logic [1:0] MODE_8  = 2'd0;
    localparam logic [1:0] MODE_16 = 2'd1;

    typedef struct packed {
        op_t        kind;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  unit_mode;
        logic [30:0] out_size;
    } cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic [1:0] status;
    } result_t;

endpackage

`default_nettype wire

// File: design/rleu_front.sv
// Front end: classifies each accepted request into a command for the queue.
// Depends on rleu_pkg.
`default_nettype none

module rleu_front
    import rleu_pkg::*;
(
    input  wire logic [1:0] operation,
    input  wire logic [7:0] in_byte,
    output cmd_t            cmd
);

    always_comb begin
        cmd.data = 8'd0;
        unique case (operation)
            OP_PUSH: begin
                cmd.kind = OP_PUSH;
                cmd.data = in_byte;
            end
            OP_PULL:  cmd.kind = OP_PULL;
            OP_START: cmd.kind = OP_START;
            default:  cmd.kind = OP_BAD;
        endcase
    end

endmodule

`default_nettype wire

// File: design/rleu_queue.sv
// Short command queue between the front end and the decode engine.
// Depends on rleu_pkg.
`default_nettype none

module rleu_queue
    import rleu_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  cmd_t      wr_cmd,
    output logic      rd_valid,
    input  wire logic rd_ready,
    output cmd_t      rd_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          push, pop;

    assign wr_ready = (cnt_reg != FULL_CNT);
    assign rd_valid = (cnt_reg != '0);
    assign rd_cmd   = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

// File: design/rleu_back.sv
// Decode engine: runs the phase machine on queued commands and holds the
// result register. Depends on rleu_pkg.
`default_nettype none

module rleu_back
    import rleu_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  cfg_t      cfg,
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    input  cmd_t      cmd,
    output logic      res_valid,
    input  wire logic res_ready,
    output result_t   res
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  bin_reg, bin_next;
    logic [31:0] ca_reg, ca_next;
    logic [31:0] ul_reg, ul_next;
    logic [31:0] pat_reg, pat_next;
    logic [30:0] bl_reg, bl_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, res_now;

    logic        fire;
    logic [2:0]  n;
    logic [1:0]  n_m1;
    logic [1:0]  bin_inc;
    logic        close;
    logic [31:0] ul_dec;
    logic [30:0] bl_dec;
    logic        literal, do_pull, do_emit;
    logic [31:0] ca_shift, pat_shift;
    logic [31:0] mask, v, v_neg, sign_val;
    logic        v_sign;
    logic [1:0]  idx, sel;
    logic [7:0]  pat_byte;

    assign fire      = cmd_valid && (!out_valid_reg || res_ready);
    assign cmd_ready = fire;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // Unit geometry from the live mode register; mode three acts as 32-bit
    always_comb begin
        case (cfg.unit_mode)
            MODE_8: begin
                n = 3'd1; mask = 32'h0000_00FF; sign_val = 32'h0000_0080;
            end
            MODE_16: begin
                n = 3'd2; mask = 32'h0000_FFFF; sign_val = 32'h0000_8000;
            end
            default: begin
                n = 3'd4; mask = 32'hFFFF_FFFF; sign_val = 32'h8000_0000;
            end
        endcase
    end

    assign n_m1      = 2'(n - 3'd1);
    assign bin_inc   = bin_reg + 2'd1;
    assign close     = ({1'b0, bin_inc} >= n) || (bin_inc == 2'd0);
    assign ul_dec    = ul_reg - 32'd1;
    assign bl_dec    = bl_reg - 31'd1;
    assign ca_shift  = {ca_reg[23:0], cmd.data};
    assign pat_shift = {pat_reg[23:0], cmd.data};
    assign v         = ca_shift & mask;
    assign v_sign    = (v & sign_val) != 32'd0;
    assign v_neg     = (~v + 32'd1) & mask;

    assign literal = (cmd.kind == OP_PUSH) && (phase_reg == PH_COUNT) && (ul_reg != 32'd0);
    assign do_pull = (cmd.kind == OP_PULL) && (phase_reg == PH_REPEAT);
    assign do_emit = literal || do_pull;

    // Repeated bytes go out most significant first; a stale position past
    // the unit end reads the last byte
    assign idx = ({1'b0, bin_reg} < n) ? bin_reg : n_m1;
    assign sel = n_m1 - idx;
    always_comb begin
        case (sel)
            2'd0:    pat_byte = pat_reg[7:0];
            2'd1:    pat_byte = pat_reg[15:8];
            2'd2:    pat_byte = pat_reg[23:16];
            default: pat_byte = pat_reg[31:24];
        endcase
    end

    // Next state
    always_comb begin
        phase_next = phase_reg;
        bin_next   = bin_reg;
        ca_next    = ca_reg;
        ul_next    = ul_reg;
        pat_next   = pat_reg;
        bl_next    = bl_reg;
        if (fire) begin
            unique case (cmd.kind)
                OP_START: begin
                    bl_next    = cfg.out_size;
                    phase_next = (cfg.out_size == 31'd0) ? PH_DONE : PH_COUNT;
                    bin_next   = 2'd0;
                    ca_next    = 32'd0;
                    ul_next    = 32'd0;
                    pat_next   = 32'd0;
                end
                OP_BAD: begin
                end
                OP_PULL, OP_PUSH: begin
                    if (do_emit) begin
                        if (close) begin
                            bin_next = 2'd0;
                            ul_next  = ul_dec;
                            if (ul_dec == 32'd0) begin
                                phase_next = PH_COUNT;
                            end
                        end else begin
                            bin_next = bin_inc;
                        end
                        bl_next = bl_dec;
                        if (bl_dec == 31'd0) begin
                            phase_next = PH_DONE;
                            bin_next   = 2'd0;
                            ul_next    = 32'd0;
                        end
                    end else if (cmd.kind == OP_PUSH && phase_reg == PH_COUNT) begin
                        ca_next  = ca_shift;
                        bin_next = bin_inc;
                        if (close) begin
                            if (v_sign) begin
                                ul_next    = (v_neg == 32'd0) ? sign_val : v_neg;
                                phase_next = PH_COUNT;
                            end else begin
                                ul_next    = v + 32'd2;
                                phase_next = PH_PATTERN;
                            end
                            bin_next = 2'd0;
                            ca_next  = 32'd0;
                            pat_next = 32'd0;
                        end
                    end else if (cmd.kind == OP_PUSH && phase_reg == PH_PATTERN) begin
                        pat_next = pat_shift;
                        bin_next = bin_inc;
                        if (close) begin
                            bin_next   = 2'd0;
                            phase_next = PH_REPEAT;
                        end
                    end
                end
            endcase
        end
    end

    // Result of the command under way
    always_comb begin
        res_now.out_byte = 8'd0;
        res_now.last     = 1'b0;
        res_now.status   = ST_TAKEN;
        unique case (cmd.kind)
            OP_START: res_now.status = ST_TAKEN;
            OP_BAD:   res_now.status = ST_REFUSED;
            OP_PULL, OP_PUSH: begin
                if (phase_reg == PH_DONE) begin
                    res_now.status = ST_IGNORED;
                end else if (do_emit) begin
                    res_now.status   = ST_BYTE;
                    res_now.out_byte = do_pull ? pat_byte : cmd.data;
                    res_now.last     = (bl_dec == 31'd0);
                end else if (cmd.kind == OP_PULL || phase_reg == PH_REPEAT) begin
                    res_now.status = ST_REFUSED;
                end
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (res_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_DONE;
            bin_reg       <= 2'd0;
            ca_reg        <= 32'd0;
            ul_reg        <= 32'd0;
            pat_reg       <= 32'd0;
            bl_reg        <= 31'd0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            bin_reg       <= bin_next;
            ca_reg        <= ca_next;
            ul_reg        <= ul_next;
            pat_reg       <= pat_next;
            bl_reg        <= bl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= res_now;
        end
    end

endmodule

`default_nettype wire

// File: design/rle_unit_decompressor.sv
// Run-length unit decompressor, top level: config registers, front end,
// command queue and decode engine. Depends on rleu_pkg and the rleu_ modules.
// A request's result is valid once it has passed the queue and the result register.
// Throughput: one request per cycle while the queue has room; the decode engine
// retires one command per cycle whenever the result register is free or draining.
// Reset (synchronous, aresetn low): queue empty, no result, phase complete,
// unit_mode 0, out_size 1.
`default_nettype none

module rle_unit_decompressor
    import rleu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tlast,
    output logic [1:0]       m_tuser,   // [1:0] status
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [30:0] cfg_data
);

    cfg_t    cfg_reg, cfg_next;
    cmd_t    front_cmd, queue_cmd;
    logic    queue_valid, queue_ready;
    result_t res;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_UNIT_MODE: cfg_next.unit_mode = cfg_data[1:0];
                CFG_OUT_SIZE:  cfg_next.out_size  = cfg_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.unit_mode <= MODE_8;
            cfg_reg.out_size  <= 31'd1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    rleu_front u_front (
        .operation (s_tuser),
        .in_byte   (s_tdata),
        .cmd       (front_cmd)
    );

    rleu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_cmd   (front_cmd),
        .rd_valid (queue_valid),
        .rd_ready (queue_ready),
        .rd_cmd   (queue_cmd)
    );

    rleu_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .cmd       (queue_cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = res.out_byte;
    assign m_tlast = res.last;
    assign m_tuser = res.status;

endmodule

`default_nettype wire

// File: design/rleu_checker.sv
// Port-level checks for the run-length unit decompressor, bound to the top.
// Depends on rleu_pkg and rle_unit_decompressor.
`default_nettype none

module rleu_checker
    import rleu_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic [1:0] m_tuser
);

    // Only a produced byte may close the stream
    a_last_is_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == ST_BYTE)
        else $error("last flag on a result without a byte");

    // Results without a byte carry zero data
    a_nobyte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_BYTE |-> m_tdata == 8'd0)
        else $error("nonzero data on a result without a byte");

    // Hold a stalled result
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

bind rle_unit_decompressor rleu_checker u_rleu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// File: bench/rle_unit_decompressor_tb.sv
// Self-checking bench for rle_unit_decompressor: directed and random push, pull, start
// and operation-three requests, with a scoreboard class that predicts every result in order.
// Depends on rleu_pkg and the RTL of the block only.
`default_nettype none

import rleu_pkg::*;

class decoder_scoreboard;
    logic [1:0]  unit_mode;
    logic [30:0] out_size;
    phase_t      phase;
    logic [1:0]  byte_pos;
    logic [31:0] count_acc;
    logic [31:0] units_left;
    logic [31:0] pattern;
    logic [30:0] bytes_left;
    result_t     owed_results[$];
    int unsigned failures;

    function new();
        unit_mode  = MODE_8;
        out_size   = 31'd1;
        phase      = PH_DONE;
        byte_pos   = 2'd0;
        count_acc  = 32'd0;
        units_left = 32'd0;
        pattern    = 32'd0;
        bytes_left = 31'd0;
        failures   = 0;
    endfunction

    function void write_register(logic index, logic [30:0] value);
        if (index == CFG_UNIT_MODE) begin
            unit_mode = value[1:0];
        end else begin
            out_size = value;
        end
    endfunction

    // Mode three falls back to 32-bit units
    function int unsigned unit_len();
        if (unit_mode == MODE_8) return 1;
        if (unit_mode == MODE_16) return 2;
        return 4;
    endfunction

    // Advance within a literal or repeated unit; a position past the unit end closes it
    function void next_unit_byte(int unsigned n);
        byte_pos = byte_pos + 2'd1;
        if (byte_pos >= n || byte_pos == 2'd0) begin
            byte_pos   = 2'd0;
            units_left = units_left - 32'd1;
            if (units_left == 32'd0) phase = PH_COUNT;
        end
    endfunction

    function logic emit_byte();
        bytes_left = bytes_left - 31'd1;
        if (bytes_left == 31'd0) begin
            phase      = PH_DONE;
            byte_pos   = 2'd0;
            units_left = 32'd0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function logic [1:0] note_request(op_t op, logic [7:0] data);
        int unsigned n;
        int unsigned idx;
        int unsigned bits;
        logic [31:0] mask;
        logic [31:0] sign;
        logic [31:0] v;
        result_t     r;
        n = unit_len();
        r = '0;
        r.status = ST_TAKEN;
        if (op == OP_START) begin
            bytes_left = out_size;
            phase      = (out_size == 31'd0) ? PH_DONE : PH_COUNT;
            byte_pos   = 2'd0;
            count_acc  = 32'd0;
            units_left = 32'd0;
            pattern    = 32'd0;
        end else if (op == OP_BAD) begin
            r.status = ST_REFUSED;
        end else if (phase == PH_DONE) begin
            r.status = ST_IGNORED;
        end else if (op == OP_PULL) begin
            if (phase != PH_REPEAT) begin
                r.status = ST_REFUSED;
            end else begin
                idx = (32'(byte_pos) < n) ? 32'(byte_pos) : n - 1;
                r.out_byte = 8'(pattern >> (8 * (n - 1 - idx)));
                r.status   = ST_BYTE;
                next_unit_byte(n);
                r.last = emit_byte();
            end
        end else if (phase == PH_REPEAT) begin
            r.status = ST_REFUSED;
        end else if (phase == PH_COUNT && units_left != 32'd0) begin
            r.out_byte = data;
            r.status   = ST_BYTE;
            next_unit_byte(n);
            r.last = emit_byte();
        end else if (phase == PH_COUNT) begin
            count_acc = {count_acc[23:0], data};
            byte_pos  = byte_pos + 2'd1;
            if (byte_pos >= n || byte_pos == 2'd0) begin
                bits = 8 * n;
                mask = (bits == 32) ? 32'hFFFF_FFFF : (32'd1 << bits) - 32'd1;
                v    = count_acc & mask;
                sign = 32'd1 << (bits - 1);
                if ((v & sign) != 32'd0) begin
                    // negative count: literal units follow; the most negative one wraps to sign
                    units_left = (32'd0 - v) & mask;
                    if (units_left == 32'd0) units_left = sign;
                end else begin
                    units_left = v + 32'd2;
                    phase      = PH_PATTERN;
                end
                byte_pos  = 2'd0;
                count_acc = 32'd0;
                pattern   = 32'd0;
            end
        end else begin
            pattern  = {pattern[23:0], data};
            byte_pos = byte_pos + 2'd1;
            if (byte_pos >= n || byte_pos == 2'd0) begin
                byte_pos = 2'd0;
                phase    = PH_REPEAT;
            end
        end
        owed_results.push_back(r);
        return r.status;
    endfunction

    function void check_result(result_t got);
        result_t want;
        if (owed_results.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("unexpected result: byte %02h last %0d status %0d",
                         got.out_byte, got.last, got.status);
            return;
        end
        want = owed_results.pop_front();
        if (got.out_byte !== want.out_byte || got.last !== want.last ||
            got.status !== want.status) begin
            failures++;
            if (failures <= 10)
                $display("mismatch (byte/last/status): expected %02h/%0d/%0d, got %02h/%0d/%0d",
                         want.out_byte, want.last, want.status,
                         got.out_byte, got.last, got.status);
        end
    endfunction
endclass

module rle_unit_decompressor_tb;

    localparam logic [1:0]  MODE_32      = 2'd2;
    localparam logic [1:0]  MODE_32_ALT  = 2'd3;
    localparam int unsigned RANDOM_ITEMS = 1550;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic [1:0]  s_tuser   = OP_PUSH;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_UNIT_MODE;
    logic [30:0] cfg_data  = 31'd0;

    decoder_scoreboard sb = new();

    int unsigned send_idle_pct = 21;
    int unsigned recv_idle_pct = 62;
    int unsigned useful_items  = 0;
    logic [31:0] planned_count = 32'd0;

    rle_unit_decompressor i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Result side: check each accepted result, then decide on stalling for the next cycle
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready)
            sb.check_result({m_tdata, m_tlast, m_tuser});
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_request(op_t op, logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (sb.note_request(op, data) != ST_IGNORED) useful_items++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.owed_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Hold cfg_valid across both writes, drop it after the second
    task automatic configure(logic [1:0] mode, logic [30:0] size);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_UNIT_MODE;
        cfg_data  <= {29'd0, mode};
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_register(CFG_UNIT_MODE, {29'd0, mode});
        cfg_index <= CFG_OUT_SIZE;
        cfg_data  <= size;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_register(CFG_OUT_SIZE, size);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_count(int unsigned n);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45) return 32'd0 - 32'($urandom_range(4, 1));
        if (r < 90) return 32'($urandom_range(4));
        if (r < 95) return $urandom();
        return 32'd1 << (8 * n - 1);
    endfunction

    function automatic logic [30:0] pick_out_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return 31'($urandom_range(24, 1));
        if (r < 85) return 31'($urandom_range(120, 25));
        if (r < 90) return 31'd0;
        if (r < 95) return 31'h7FFF_FFFF;
        return 31'($urandom());
    endfunction

    // Follow the predicted phase to build well-formed streams, with some noise mixed in
    task automatic send_next();
        op_t         op;
        logic [7:0]  data;
        int unsigned n;
        int unsigned pos;
        n    = sb.unit_len();
        pos  = 32'(sb.byte_pos);
        data = 8'($urandom_range(255));
        op   = OP_PUSH;
        if ($urandom_range(99) < 8) begin
            op = op_t'($urandom_range(3));
        end else begin
            case (sb.phase)
                PH_DONE:   op = OP_START;
                PH_REPEAT: op = OP_PULL;
                PH_COUNT: begin
                    if (sb.units_left == 32'd0) begin
                        if (pos == 0) planned_count = pick_count(n);
                        data = (pos < n) ? 8'(planned_count >> (8 * (n - 1 - pos)))
                                         : 8'(planned_count);
                    end
                end
                default: op = OP_PUSH;
            endcase
        end
        send_request(op, data);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Nothing started yet: push and pull are ignored, operation three refused
        send_request(OP_PUSH, 8'h00);
        send_request(OP_PULL, 8'hFF);
        send_request(OP_BAD, 8'h5A);

        configure(MODE_8, 31'd6);
        send_request(OP_START, 8'h00);
        send_request(OP_PULL, 8'h00);
        send_request(OP_PUSH, 8'hFE);
        send_request(OP_PUSH, 8'h00);
        send_request(OP_PUSH, 8'hFF);
        send_request(OP_PUSH, 8'h01);
        send_request(OP_PUSH, 8'hA5);
        send_request(OP_PUSH, 8'h11);
        send_request(OP_PULL, 8'h00);
        send_request(OP_PULL, 8'h00);
        send_request(OP_PULL, 8'h00);
        // long literal run cut short by the end of the stream
        send_request(OP_PUSH, 8'h80);
        send_request(OP_PUSH, 8'h3C);
        send_request(OP_PUSH, 8'h3D);

        // Most negative 32-bit count, then narrow the units in the middle of a unit
        configure(MODE_32_ALT, 31'd3);
        send_request(OP_START, 8'h00);
        send_request(OP_PUSH, 8'h80);
        send_request(OP_PUSH, 8'h00);
        send_request(OP_PUSH, 8'h00);
        send_request(OP_PUSH, 8'h00);
        send_request(OP_PUSH, 8'h11);
        configure(MODE_8, 31'd3);
        send_request(OP_PUSH, 8'h22);
        send_request(OP_PUSH, 8'h33);

        configure(MODE_16, 31'd0);
        send_request(OP_START, 8'h00);
        send_request(OP_PUSH, 8'h44);
        configure(MODE_32, 31'h7FFF_FFFF);
        send_request(OP_START, 8'h00);

        useful_items = 0;
        while (useful_items < RANDOM_ITEMS) begin
            if (useful_items < RANDOM_ITEMS / 3) begin
                send_idle_pct = 21;
                recv_idle_pct = 62;
            end else if (useful_items < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 62;
                recv_idle_pct = 21;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            configure(2'($urandom_range(3)), pick_out_size());
            repeat ($urandom_range(90, 40)) send_next();
        end

        drain();
        repeat (8) @(posedge aclk);
        if (sb.failures == 0 && sb.owed_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
